// ===== rtl/dss_pkg.sv =====
// Package for the difference spike statistics block.
// Holds sizing constants, register indexes and status codes; no dependencies.
package dss_pkg;
    localparam int DEF_BUFFER_DEPTH = 4096;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int CFG_ADDR_BITS = 4;
    localparam logic [12:0] RST_MIN_SAMPLES = 13'd100;
    localparam logic [7:0] RST_LOW_MULT = 8'd10;
    localparam logic [7:0] RST_HIGH_MULT = 8'd50;
    localparam logic [23:0] RATIO_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        REG_MIN_SAMPLES = 2'd0,
        REG_LOW_MULT = 2'd1,
        REG_HIGH_MULT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_TOO_FEW = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;
endpackage

// ===== rtl/difference_spike_statistics.sv =====
// Top level of the difference spike statistics block.
// Depends on dss_pkg. After the last sample it forms the products, runs the
// variance and mean divides, takes the square root, rescans the stored
// differences, runs the ratio divide and then raises o_valid; with too few
// samples it goes from the products state straight to the output state.
// Throughput: one sample per cycle until the last; busy covers the final pass.
// Reset is synchronous and active low; it clears control state, not memory.
module difference_spike_statistics
    import dss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DEF_SAMPLE_BITS-1:0] i_sample,
    input  logic                     i_last_sample,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic [12:0]              o_sample_count,
    output logic [23:0]              o_std_dev,
    output logic [15:0]              o_max_diff,
    output logic [23:0]              o_max_over_std,
    output logic [11:0]              o_count_low,
    output logic [11:0]              o_count_high
);
    localparam int BUFFER_DEPTH = DEF_BUFFER_DEPTH;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = AW + 1;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int SW = DW + CW;
    localparam int QW = 2 * DW + CW;
    localparam int NW = QW + CW;
    localparam int VW = NW + 16;
    localparam int RW = (VW + 1) / 2;
    localparam int XW = 2 * RW;
    localparam int TW = RW + 9 + DW + 8;

    typedef enum logic [2:0] {
        S_LOAD, S_MUL, S_DIV, S_SQRT, S_SCAN, S_RDIV, S_OUT
    } t_state;

    logic [15:0] mem [BUFFER_DEPTH];
    logic [15:0] r_rd;

    t_state r_state;
    logic [12:0] r_min;
    logic [7:0] r_lo_m, r_hi_m;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic [CW-1:0] r_taken;
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sq;
    logic r_ovf;
    logic [NW-1:0] r_num;
    logic [2*CW-1:0] r_n2;
    logic [VW-1:0] r_q, r_rem;
    logic [7:0] r_cnt;
    logic [XW-1:0] r_x, r_res, r_bit;
    logic [SW+8-1:0] r_mq, r_mr;
    logic [TW-1:0] r_tlo, r_thi;
    logic [CW-1:0] r_addr;
    logic [CW:0] r_seen;
    logic r_rvalid;
    logic [11:0] r_clo, r_chi;
    logic [15:0] r_max;
    logic [40:0] r_dq, r_dr;

    logic wr_en;
    logic signed [SAMPLE_BITS:0] delta;
    logic [DW-1:0] dabs;
    logic accept;
    logic [CW-1:0] n_cnt;

    assign accept = start && !busy;
    assign busy = (r_state != S_LOAD);
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign delta = {i_sample[SAMPLE_BITS-1], i_sample} - {r_prev[SAMPLE_BITS-1], r_prev};
    assign dabs = delta[SAMPLE_BITS] ? DW'(-delta) : DW'(delta);
    assign n_cnt = r_taken - CW'(1);

    always_comb begin
        prdata = '0;
        case (paddr[CFG_ADDR_BITS-1:2])
            REG_MIN_SAMPLES: prdata = 32'(r_min);
            REG_LOW_MULT: prdata = 32'(r_lo_m);
            REG_HIGH_MULT: prdata = 32'(r_hi_m);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_taken != '0 && r_taken < CW'(BUFFER_DEPTH)) begin
            mem[AW'(r_taken - CW'(1))] <= 16'(dabs);
        end
        r_rd <= mem[AW'(r_addr)];
    end

    logic [VW-1:0] rem_sh;
    logic [XW-1:0] sq_try;
    logic [41:0] dr_sh;
    logic [TW-1:0] dv;
    assign rem_sh = {r_rem[VW-2:0], r_q[VW-1]};
    assign sq_try = r_res + r_bit;
    assign dr_sh = {r_dr, r_dq[40]};
    assign dv = TW'(r_rd) << 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_min <= RST_MIN_SAMPLES;
            r_lo_m <= RST_LOW_MULT;
            r_hi_m <= RST_HIGH_MULT;
            r_prev <= '0;
            r_taken <= '0;
            r_sum <= '0;
            r_sq <= '0;
            r_ovf <= 1'b0;
            o_valid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (wr_en) begin
                case (paddr[CFG_ADDR_BITS-1:2])
                    REG_MIN_SAMPLES: r_min <= pwdata[12:0];
                    REG_LOW_MULT: r_lo_m <= pwdata[7:0];
                    REG_HIGH_MULT: r_hi_m <= pwdata[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (r_taken >= CW'(BUFFER_DEPTH)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            if (r_taken != '0) begin
                                r_sum <= r_sum + SW'(dabs);
                                r_sq <= r_sq + QW'(dabs) * QW'(dabs);
                            end
                            r_prev <= i_sample;
                            r_taken <= r_taken + CW'(1);
                        end
                        if (i_last_sample) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    o_sample_count <= 13'(r_taken);
                    o_status <= ST_TOO_FEW;
                    o_std_dev <= '0;
                    o_max_diff <= '0;
                    o_max_over_std <= '0;
                    o_count_low <= '0;
                    o_count_high <= '0;
                    if (13'(r_taken) < r_min || r_taken < CW'(2)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_num <= NW'(n_cnt) * NW'(r_sq) - NW'(r_sum) * NW'(r_sum);
                        r_n2 <= (2*CW)'(n_cnt) * (2*CW)'(n_cnt);
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_mr <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_q <= VW'(r_num) << 16;
                        r_mq <= (SW+8)'(r_sum) << 8;
                        r_cnt <= 8'd1;
                    end else begin
                        if (rem_sh >= VW'(r_n2)) begin
                            r_rem <= rem_sh - VW'(r_n2);
                            r_q <= {r_q[VW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_q <= {r_q[VW-2:0], 1'b0};
                        end
                        if (r_cnt <= 8'(SW + 8)) begin
                            if ({r_mr[SW+6:0], r_mq[SW+7]} >= (SW+8)'(n_cnt)) begin
                                r_mr <= {r_mr[SW+6:0], r_mq[SW+7]} - (SW+8)'(n_cnt);
                                r_mq <= {r_mq[SW+6:0], 1'b1};
                            end else begin
                                r_mr <= {r_mr[SW+6:0], r_mq[SW+7]};
                                r_mq <= {r_mq[SW+6:0], 1'b0};
                            end
                        end
                        if (r_cnt == 8'(VW)) begin
                            r_cnt <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_cnt == '0) begin
                        r_x <= XW'(r_q);
                        r_res <= '0;
                        r_bit <= XW'(1) << (XW - 2);
                        r_cnt <= 8'd1;
                    end else if (r_bit != '0) begin
                        if (r_x >= sq_try) begin
                            r_x <= r_x - sq_try;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_tlo <= TW'(r_mq) + TW'(r_lo_m) * TW'(r_res);
                        r_thi <= TW'(r_mq) + TW'(r_hi_m) * TW'(r_res);
                        o_std_dev <= 24'(r_res);
                        r_addr <= '0;
                        r_seen <= '0;
                        r_clo <= '0;
                        r_chi <= '0;
                        r_max <= '0;
                        r_rvalid <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rvalid <= (r_addr < n_cnt);
                    if (r_addr < n_cnt) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    if (r_rvalid) begin
                        r_seen <= r_seen + (CW+1)'(1);
                        if (dv > r_tlo) r_clo <= r_clo + 12'd1;
                        if (dv > r_thi) r_chi <= r_chi + 12'd1;
                        if (r_rd > r_max) r_max <= r_rd;
                    end
                    if (!r_rvalid && r_addr >= n_cnt && r_seen != '0) begin
                        r_dq <= 41'(r_max) << 16;
                        r_dr <= '0;
                        r_cnt <= '0;
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (r_cnt == 8'd41) begin
                        o_max_diff <= r_max;
                        o_count_low <= r_clo;
                        o_count_high <= r_chi;
                        o_status <= r_ovf ? ST_OVERFLOW : ST_OK;
                        o_max_over_std <= (r_res == '0 || r_dq[40:24] != '0) ?
                            RATIO_MAX : r_dq[23:0];
                        r_state <= S_OUT;
                    end else begin
                        if (dr_sh >= 42'(r_res)) begin
                            r_dr <= 41'(dr_sh - 42'(r_res));
                            r_dq <= {r_dq[39:0], 1'b1};
                        end else begin
                            r_dr <= 41'(dr_sh);
                            r_dq <= {r_dq[39:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 8'd1;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_prev <= '0;
                    r_taken <= '0;
                    r_sum <= '0;
                    r_sq <= '0;
                    r_ovf <= 1'b0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== rtl/dss_checker.sv =====
// Port-level checker for difference_spike_statistics, bound to the top level.
// Depends on dss_pkg for status codes.
module dss_checker
    import dss_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_sample,
    input logic o_valid,
    input logic [1:0] o_status,
    input logic [23:0] o_std_dev,
    input logic [11:0] o_count_low,
    input logic [11:0] o_count_high
);
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_sample |=> busy) else $error("no busy after last");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result longer than one cycle");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_TOO_FEW ||
            o_status == ST_OVERFLOW) else $error("bad status");
    a_too_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_TOO_FEW |->
            o_std_dev == '0 && o_count_low == '0 && o_count_high == '0)
        else $error("too few result not zero");
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy during result");
endmodule

bind difference_spike_statistics dss_checker u_dss_checker (.*);
